>>> src/smbus_register_read_with_pec_assert.svh
// Assertion macros used by the checker file.
`ifndef SMBUS_REGISTER_READ_WITH_PEC_ASSERT_SVH
`define SMBUS_REGISTER_READ_WITH_PEC_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during rst.
`define SPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smbus pec check failed");

// Next-cycle implication, sampled on clk, held off during rst.
`define SPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smbus pec check failed");

`endif

>>> src/smbus_pec_pkg.sv
package smbus_pec_pkg;

  // Default register count
  localparam int REG_COUNT_DEF = 32;

  // CRC-8 polynomial, no reflection, no final xor
  localparam logic [7:0] PEC_POLY = 8'h07;

  // Bus event codes
  typedef enum logic [2:0] {
    OP_ADDR_MATCH = 3'd0,
    OP_STOP       = 3'd1,
    OP_WRITE_BYTE = 3'd2,
    OP_READ_BYTE  = 3'd3,
    OP_REG_UPDATE = 3'd4
  } op_t;

  // Response codes
  typedef enum logic [1:0] {
    RSP_ACK  = 2'd0,
    RSP_NACK = 2'd1,
    RSP_DONE = 2'd2
  } rsp_t;

  // One result word
  typedef struct packed {
    logic [1:0] response;
    logic [7:0] read_data;
    logic       read_valid;
  } res_t;

  // Fold one byte into the CRC-8
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ PEC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> src/smbus_pec_regfile.sv
// Register file: synchronous memory, one write and one read port,
// registered read data. Valid bits stand in for the all-zero reset.
module smbus_pec_regfile #(
  parameter int REG_COUNT = smbus_pec_pkg::REG_COUNT_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               wr_en,
  input  logic [((REG_COUNT > 1) ? $clog2(REG_COUNT) : 1)-1:0] wr_addr,
  input  logic [15:0]                                        wr_data,
  input  logic                                               rd_en,
  input  logic [((REG_COUNT > 1) ? $clog2(REG_COUNT) : 1)-1:0] rd_addr,
  output logic [15:0]                                        rd_data
);

  logic [15:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [15:0]          data_q;
  logic                 vld_q;

  // Storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  // Per-entry valid bits and registered read valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  // Unwritten entries read as zero
  assign rd_data = vld_q ? data_q : 16'h0000;

endmodule

>>> src/smbus_pec_obuf.sv
// Two-entry output buffer: main register plus skid slot.
module smbus_pec_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  smbus_pec_pkg::res_t  din,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smbus_pec_pkg::res_t  dout
);

  logic                main_v;
  logic                skid_v;
  smbus_pec_pkg::res_t main_q;
  smbus_pec_pkg::res_t skid_q;
  logic                main_free;

  // main slot is open at this edge when empty or drained
  assign main_free  = !main_v || out_ready;
  assign push_ready = !skid_v;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (main_free) begin
      main_v <= skid_v || push;
      skid_v <= skid_v && push;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_v) begin
        main_q <= skid_q;
        if (push) begin
          skid_q <= din;
        end
      end else if (push) begin
        main_q <= din;
      end
    end else if (push) begin
      skid_q <= din;
    end
  end

  assign out_valid = main_v;
  assign dout      = main_q;

endmodule

>>> src/smbus_register_read_with_pec.sv
// Channel | Handshake              | Payload
// input   | in_valid / in_ready    | opcode, data_byte, update_index, update_value
// output  | out_valid / out_ready  | response, read_data, read_valid
// config  | cfg_we (no wait)       | cfg_wdata (device address)
//
// One bus event per cycle while in_ready is high; each result is registered
// in the output buffer. A command reads the register memory, whose read data
// is registered; the following read sees the fetched word through a bypass.
// rst is synchronous: PEC, byte count, latched word, device address and
// memory valid bits clear at once, so no clearing pass is needed.
// A stalled output keeps up to two results; in_ready drops only then.
module smbus_register_read_with_pec #(
  parameter int REG_COUNT = smbus_pec_pkg::REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [4:0]  update_index,
  input  logic [15:0] update_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  response,
  output logic [7:0]  read_data,
  output logic        read_valid,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int         AW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [8:0] RC9 = 9'(REG_COUNT);

  logic [6:0]          dev_addr;
  logic [7:0]          pec;
  logic [7:0]          pec_next;
  logic [1:0]          byte_cnt;
  logic [1:0]          byte_cnt_next;
  logic [15:0]         latched_word;
  logic                lat_pend;
  logic [15:0]         lat_eff;
  logic [15:0]         rf_rdata;
  logic                rd_en;
  logic                wr_en;
  logic [7:0]          upd_ext;
  logic [7:0]          addr_byte;
  logic [7:0]          pec_a;
  logic [7:0]          rbyte;
  logic                in_acc;
  logic                push;
  smbus_pec_pkg::res_t res;
  smbus_pec_pkg::res_t res_q;
  smbus_pec_pkg::op_t  op;

  assign in_acc  = in_valid && in_ready;
  assign op      = smbus_pec_pkg::op_t'(opcode);
  assign upd_ext = {3'b000, update_index};
  assign lat_eff = lat_pend ? rf_rdata : latched_word;

  // Address byte folds in at byte count zero
  assign addr_byte = {dev_addr, (op == smbus_pec_pkg::OP_READ_BYTE)};
  assign pec_a     = (byte_cnt == 2'd0) ? smbus_pec_pkg::crc8_fold(pec, addr_byte) : pec;
  assign rbyte     = (byte_cnt == 2'd0) ? lat_eff[7:0] : lat_eff[15:8];

  // Event decode
  always_comb begin
    pec_next      = pec;
    byte_cnt_next = byte_cnt;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    push          = 1'b0;
    res           = '{response: smbus_pec_pkg::RSP_ACK, read_data: 8'h00, read_valid: 1'b0};
    if (in_acc) begin
      case (op)
        smbus_pec_pkg::OP_ADDR_MATCH: begin
          byte_cnt_next = 2'd0;
          push          = 1'b1;
        end
        smbus_pec_pkg::OP_STOP: begin
          res.response = smbus_pec_pkg::RSP_DONE;
          push         = 1'b1;
        end
        smbus_pec_pkg::OP_WRITE_BYTE: begin
          push = 1'b1;
          if ({1'b0, data_byte} < RC9) begin
            rd_en    = 1'b1;
            pec_next = smbus_pec_pkg::crc8_fold(pec_a, data_byte);
          end else begin
            pec_next     = pec_a;
            res.response = smbus_pec_pkg::RSP_NACK;
          end
        end
        smbus_pec_pkg::OP_READ_BYTE: begin
          push           = 1'b1;
          res.read_valid = 1'b1;
          if (byte_cnt < 2'd2) begin
            res.read_data = rbyte;
            byte_cnt_next = byte_cnt + 2'd1;
            pec_next      = smbus_pec_pkg::crc8_fold(pec_a, rbyte);
          end else begin
            res.read_data = pec_a;
            res.response  = smbus_pec_pkg::RSP_NACK;
            pec_next      = 8'h00;
          end
        end
        smbus_pec_pkg::OP_REG_UPDATE: begin
          wr_en = ({4'b0000, update_index} < RC9);
        end
        default: begin
        end
      endcase
    end
  end

  // Engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      pec          <= 8'h00;
      byte_cnt     <= 2'd0;
      latched_word <= 16'h0000;
      lat_pend     <= 1'b0;
      dev_addr     <= 7'h00;
    end else begin
      pec      <= pec_next;
      byte_cnt <= byte_cnt_next;
      if (lat_pend) begin
        latched_word <= rf_rdata;
      end
      lat_pend <= rd_en;
      if (cfg_we) begin
        dev_addr <= cfg_wdata;
      end
    end
  end

  smbus_pec_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_rf (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(upd_ext[AW-1:0]),
    .wr_data(update_value),
    .rd_en  (rd_en),
    .rd_addr(data_byte[AW-1:0]),
    .rd_data(rf_rdata)
  );

  smbus_pec_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .push_ready(in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_q)
  );

  assign response   = res_q.response;
  assign read_data  = res_q.read_data;
  assign read_valid = res_q.read_valid;

endmodule

>>> src/smbus_pec_checker.sv
`include "smbus_register_read_with_pec_assert.svh"

// Port-level checks on the PEC target
module smbus_pec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] response,
  input logic [7:0] read_data,
  input logic       read_valid
);

  logic [10:0] out_word;

  // Result fields as one word
  assign out_word = {response, read_data, read_valid};

  // Stalled result holds
  `SPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // No byte is driven without a read
  `SPR_ASSERT_NOW(a_rdata_zero, out_valid && !read_valid, read_data == 8'h00)

  // A stop never carries read data
  `SPR_ASSERT_NOW(a_done_no_read, out_valid && (response == smbus_pec_pkg::RSP_DONE), !read_valid)

  // Input backs up only behind a waiting result
  `SPR_ASSERT_NOW(a_stall_cause, !in_ready, out_valid)

endmodule

bind smbus_register_read_with_pec smbus_pec_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .response  (response),
  .read_data (read_data),
  .read_valid(read_valid)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

// Tracks the target's bus state and queues the response words it should produce.
class pec_scoreboard;
  logic [15:0]         regs [smbus_pec_pkg::REG_COUNT_DEF];
  logic [15:0]         word_latch;
  logic [1:0]          rd_count;
  logic [7:0]          pec;
  logic [6:0]          dev_addr;
  smbus_pec_pkg::res_t pending_q[$];
  int                  errors;

  function void clear();
    foreach (regs[i]) regs[i] = '0;
    word_latch = '0;
    rd_count   = '0;
    pec        = '0;
    dev_addr   = '0;
    pending_q.delete();
    errors     = 0;
  endfunction

  // CRC-8, poly 0x07, MSB first
  function logic [7:0] pec_update(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ smbus_pec_pkg::PEC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Accepted input word: advance the state, queue the response if any
  function void note_input(logic [2:0] op, logic [7:0] db, logic [4:0] ui, logic [15:0] uv);
    smbus_pec_pkg::res_t exp;
    logic [7:0] addr_byte;
    exp = '0;
    exp.response = smbus_pec_pkg::RSP_ACK;
    case (op)
      smbus_pec_pkg::OP_ADDR_MATCH: rd_count = '0;
      smbus_pec_pkg::OP_STOP:       exp.response = smbus_pec_pkg::RSP_DONE;
      smbus_pec_pkg::OP_WRITE_BYTE, smbus_pec_pkg::OP_READ_BYTE: begin
        addr_byte = {dev_addr, (op == smbus_pec_pkg::OP_READ_BYTE)};
        if (rd_count == 0) pec = pec_update(pec, addr_byte);
        if (op == smbus_pec_pkg::OP_READ_BYTE) begin
          exp.read_valid = 1'b1;
          if (rd_count < 2) begin
            exp.read_data = (rd_count == 0) ? word_latch[7:0] : word_latch[15:8];
            rd_count = rd_count + 2'd1;
            pec = pec_update(pec, exp.read_data);
          end else begin
            // past the word: hand out the PEC and start over
            exp.read_data = pec;
            pec = '0;
            exp.response = smbus_pec_pkg::RSP_NACK;
          end
        end else if (db < smbus_pec_pkg::REG_COUNT_DEF) begin
          word_latch = regs[db];
          pec = pec_update(pec, db);
        end else begin
          exp.response = smbus_pec_pkg::RSP_NACK;
        end
      end
      smbus_pec_pkg::OP_REG_UPDATE: begin
        if (ui < smbus_pec_pkg::REG_COUNT_DEF) regs[ui] = uv;
        return;
      end
      default: return;
    endcase
    pending_q.push_back(exp);
  endfunction

  task check_result(logic [1:0] rsp, logic [7:0] rd, logic rv);
    smbus_pec_pkg::res_t exp;
    if (pending_q.size() == 0) begin
      report($sformatf("response word with none pending (rsp=%0d data=%02h)", rsp, rd));
      return;
    end
    exp = pending_q.pop_front();
    if (rsp !== exp.response)
      report($sformatf("response %0d, want %0d", rsp, exp.response));
    if (rd !== exp.read_data)
      report($sformatf("read_data %02h, want %02h", rd, exp.read_data));
    if (rv !== exp.read_valid)
      report($sformatf("read_valid %0b, want %0b", rv, exp.read_valid));
  endtask
endclass

module tb;
  localparam int NREGS       = smbus_pec_pkg::REG_COUNT_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 230;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  opcode;
  logic [7:0]  data_byte;
  logic [4:0]  update_index;
  logic [15:0] update_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  response;
  logic [7:0]  read_data;
  logic        read_valid;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;

  pec_scoreboard sb;
  int  items_sent;
  int  results_seen;
  int  cycle_count;
  bit  tx_idle_on;
  bit  rx_idle_on;

  smbus_register_read_with_pec dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .update_index (update_index),
    .update_value (update_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .response     (response),
    .read_data    (read_data),
    .read_valid   (read_valid),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one event word, hold it until taken, then maybe go quiet
  task automatic send_word(input logic [2:0] op, input logic [7:0] db,
                           input logic [4:0] ui, input logic [15:0] uv);
    in_valid     <= 1'b1;
    opcode       <= op;
    data_byte    <= db;
    update_index <= ui;
    update_value <= uv;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(op, db, ui, uv);
    if (op <= smbus_pec_pkg::OP_REG_UPDATE) items_sent++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Event with random don't-care fields
  task automatic send_op(input logic [2:0] op);
    send_word(op, 8'($urandom), 5'($urandom), 16'($urandom));
  endtask

  // Full read-word transaction, sometimes with a bad command, register updates or extra reads
  task automatic read_word_txn();
    logic [7:0] cmd;
    cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NREGS, 255))
                                      : 8'($urandom_range(0, NREGS - 1));
    if ($urandom_range(0, 3) == 0)
      send_word(smbus_pec_pkg::OP_REG_UPDATE, 8'($urandom), cmd[4:0], 16'($urandom));
    send_op(smbus_pec_pkg::OP_ADDR_MATCH);
    send_word(smbus_pec_pkg::OP_WRITE_BYTE, cmd, 5'($urandom), 16'($urandom));
    // local update after the command must not disturb the latched word
    if ($urandom_range(0, 4) == 0)
      send_word(smbus_pec_pkg::OP_REG_UPDATE, 8'($urandom), cmd[4:0], 16'($urandom));
    if ($urandom_range(0, 5) != 0) send_op(smbus_pec_pkg::OP_ADDR_MATCH);
    repeat (3) send_op(smbus_pec_pkg::OP_READ_BYTE);
    if ($urandom_range(0, 7) == 0) send_op(smbus_pec_pkg::OP_READ_BYTE);
    send_op(smbus_pec_pkg::OP_STOP);
  endtask

  task automatic random_phase(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2:
          repeat ($urandom_range(1, 4))
            send_word(smbus_pec_pkg::OP_REG_UPDATE, 8'($urandom), 5'($urandom),
                      16'($urandom));
        3, 4, 5, 6:
          repeat ($urandom_range(1, 6)) send_op(3'($urandom_range(0, 7)));
        default: read_word_txn();
      endcase
    end
  endtask

  // Wait out all responses plus the update path before touching config
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_address(input logic [6:0] a);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.dev_addr = a;
  endtask

  // Response side: check, random stalls, one long hold-off
  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit held;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst == 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
        sb.check_result(response, read_data, read_valid);
        results_seen++;
      end
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    logic [6:0] addr_list [5];
    sb = new();
    sb.clear();
    items_sent   = 0;
    results_seen = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    opcode       <= '0;
    data_byte    <= '0;
    update_index <= '0;
    update_value <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every event, PEC read-out and overrun
    set_address(7'h7F);
    send_word(smbus_pec_pkg::OP_REG_UPDATE, 8'h00, 5'd0, 16'hFFFF);
    send_word(smbus_pec_pkg::OP_REG_UPDATE, 8'hFF, 5'd31, 16'h1234);
    send_op(smbus_pec_pkg::OP_ADDR_MATCH);
    send_word(smbus_pec_pkg::OP_WRITE_BYTE, 8'd0, 5'd0, 16'h0000);
    send_op(smbus_pec_pkg::OP_ADDR_MATCH);
    repeat (3) send_op(smbus_pec_pkg::OP_READ_BYTE);
    send_op(smbus_pec_pkg::OP_READ_BYTE);
    send_op(smbus_pec_pkg::OP_STOP);
    send_op(smbus_pec_pkg::OP_ADDR_MATCH);
    send_word(smbus_pec_pkg::OP_WRITE_BYTE, 8'd31, 5'd31, 16'hFFFF);
    // read right behind the command, no repeated start
    repeat (3) send_op(smbus_pec_pkg::OP_READ_BYTE);
    send_op(smbus_pec_pkg::OP_STOP);
    send_op(smbus_pec_pkg::OP_ADDR_MATCH);
    send_word(smbus_pec_pkg::OP_WRITE_BYTE, 8'(NREGS), 5'd0, 16'h0000);
    send_word(smbus_pec_pkg::OP_WRITE_BYTE, 8'hFF, 5'd0, 16'h0000);
    send_op(3'd5);
    send_op(3'd6);
    send_op(3'd7);
    send_word(smbus_pec_pkg::OP_REG_UPDATE, 8'h00, 5'd31, 16'h0000);
    send_op(smbus_pec_pkg::OP_STOP);
    drain();

    addr_list[0] = 7'h00;
    addr_list[1] = 7'($urandom);
    addr_list[2] = 7'h2A;
    addr_list[3] = 7'($urandom);
    addr_list[4] = 7'h7F;
    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      set_address(addr_list[p]);
      random_phase(PHASE_ITEMS);
      drain();
    end

    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
